// ===== rtl/csr_pkg.sv =====
// Shared constants, payload types and register codes of the centroid spring restraint.
package csr_pkg;

	// Block sizing
	localparam int MAX_ATOMS       = 1024;
	localparam int COORD_FRAC_BITS = 16;

	localparam int COORD_W  = 32;
	localparam int CNT_W    = $clog2(MAX_ATOMS + 1);
	localparam int SUM_W    = COORD_W + $clog2(MAX_ATOMS);
	localparam int C_W      = COORD_W + 1;
	localparam int D_W      = COORD_W + 2;
	localparam int MAG_W    = COORD_W;
	localparam int PROD_W   = 2 * COORD_W;
	localparam int DIVR_W   = CNT_W + COORD_FRAC_BITS - 1;
	localparam int SQ_W     = PROD_W + 2;
	localparam int E_SH     = 2 * COORD_FRAC_BITS;
	localparam int ENERGY_W = 63;
	localparam int GRAD_W   = 48;
	localparam int EACC_W   = (E_SH + ENERGY_W + 1 > SQ_W + COORD_W + 2) ?
		E_SH + ENERGY_W + 1 : SQ_W + COORD_W + 2;
	localparam int LANES    = 3;

	// Bit-serial divider
	localparam int DIV_STEPS = PROD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// Group queue
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef enum logic [ADDR_W-3:0] {
		REG_FORCE_CONSTANT,
		REG_ANCHOR_X,
		REG_ANCHOR_Y,
		REG_ANCHOR_Z
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] y_coord;
		logic signed [COORD_W-1:0] z_coord;
		logic                      last_atom;
	} in_item_t;

	typedef struct packed {
		logic [ENERGY_W-1:0]      energy;
		logic signed [GRAD_W-1:0] grad_x;
		logic signed [GRAD_W-1:0] grad_y;
		logic signed [GRAD_W-1:0] grad_z;
		logic                     too_many_atoms;
	} out_item_t;

	typedef struct packed {
		logic [COORD_W-1:0]        force_constant;
		logic signed [COORD_W-1:0] anchor_x;
		logic signed [COORD_W-1:0] anchor_y;
		logic signed [COORD_W-1:0] anchor_z;
	} cfg_t;

	// One finished group, handed from the accumulator to the compute side
	typedef struct packed {
		logic signed [SUM_W-1:0] sum_x;
		logic signed [SUM_W-1:0] sum_y;
		logic signed [SUM_W-1:0] sum_z;
		logic [CNT_W-1:0]        atom_count;
		logic                    count_overflow;
	} group_t;

endpackage

// ===== rtl/csr_div.sv =====
// Restoring bit-serial divider: one quotient bit per cycle, with a round-half-up flag.
module csr_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [csr_pkg::PROD_W-1:0]  dividend,
	input  logic [csr_pkg::DIVR_W-1:0]  divisor,
	output logic                        busy,
	output logic [csr_pkg::PROD_W-1:0]  quotient,
	output logic                        round_up
);
	import csr_pkg::*;

	logic [PROD_W-1:0]    dq_q;
	logic [DIVR_W-1:0]    rem_q;
	logic [DIVR_W-1:0]    div_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [DIVR_W:0]      trial;
	logic                 fits;

	// Shift the next dividend bit into the partial remainder and try the subtract
	assign trial = {rem_q, dq_q[PROD_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Advance remainder and quotient; the dividend shifts out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DIVR_W'(trial - {1'b0, div_q}) : trial[DIVR_W-1:0];
			dq_q  <= {dq_q[PROD_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = dq_q;
	assign round_up = {rem_q, 1'b0} >= {1'b0, div_q};

endmodule

// ===== rtl/csr_front.sv =====
// Front end: accepts atoms, accumulates coordinate sums and counts, closes a group on the last atom.
module csr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  csr_pkg::in_item_t in_data,
	input  logic              q_full,
	output logic              q_push,
	output csr_pkg::group_t   q_group
);
	import csr_pkg::*;

	logic signed [SUM_W-1:0] sum_x_q;
	logic signed [SUM_W-1:0] sum_y_q;
	logic signed [SUM_W-1:0] sum_z_q;
	logic [CNT_W-1:0]        count_q;
	logic                    ovf_q;
	logic                    accept;
	logic                    room;
	group_t                  nxt;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign room     = count_q != CNT_W'(MAX_ATOMS);

	// Add the atom while there is room, otherwise drop it and flag the group
	always_comb begin
		nxt.sum_x          = sum_x_q;
		nxt.sum_y          = sum_y_q;
		nxt.sum_z          = sum_z_q;
		nxt.atom_count     = count_q;
		nxt.count_overflow = ovf_q;
		if (room) begin
			nxt.sum_x      = sum_x_q + SUM_W'(in_data.x_coord);
			nxt.sum_y      = sum_y_q + SUM_W'(in_data.y_coord);
			nxt.sum_z      = sum_z_q + SUM_W'(in_data.z_coord);
			nxt.atom_count = count_q + 1'b1;
		end else begin
			nxt.count_overflow = 1'b1;
		end
	end

	assign q_push  = accept && in_data.last_atom;
	assign q_group = nxt;

	// Hold the running group; clear it once handed to the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (accept) begin
			if (in_data.last_atom) begin
				sum_x_q <= '0;
				sum_y_q <= '0;
				sum_z_q <= '0;
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				sum_x_q <= nxt.sum_x;
				sum_y_q <= nxt.sum_y;
				sum_z_q <= nxt.sum_z;
				count_q <= nxt.atom_count;
				ovf_q   <= nxt.count_overflow;
			end
		end
	end

endmodule

// ===== rtl/csr_queue.sv =====
// Short queue of finished groups between the front end and the compute back end.
module csr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  csr_pkg::group_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output csr_pkg::group_t head
);
	import csr_pkg::*;

	group_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = cnt_q == QCNT_W'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = slot_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store the pushed group
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/csr_back.sv =====
// Back end: centroid division, displacement, energy and gradient products, gradient division, result register.
module csr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  csr_pkg::cfg_t      cfg,
	input  logic               q_empty,
	input  csr_pkg::group_t    q_head,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output csr_pkg::out_item_t out_data
);
	import csr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CDIV,
		S_MUL,
		S_GSTART,
		S_GDIV,
		S_EMIT
	} state_t;

	typedef enum logic [3:0] {
		MS_SQ_X,
		MS_SQ_Y,
		MS_SQ_Z,
		MS_E_LO,
		MS_E_MID,
		MS_E_HI,
		MS_G_X,
		MS_G_Y,
		MS_G_Z
	} mul_step_t;

	localparam logic [EACC_W-1:0] E_HALF = EACC_W'(1) << (E_SH - 1);

	state_t                  state_q;
	mul_step_t               step_q;
	logic                    phase_q;
	logic [CNT_W-1:0]        n_q;
	logic                    ovf_q;
	logic [LANES-1:0]        sneg_q;
	logic signed [D_W-1:0]   d_q [LANES];
	logic [MAG_W-1:0]        mag_d [LANES];
	logic [PROD_W-1:0]       mag_q [LANES];
	logic [SQ_W-1:0]         s_q;
	logic [EACC_W-1:0]       p_q;
	logic [PROD_W-1:0]       prod_q;
	logic                    out_valid_q;
	out_item_t               out_data_q;

	logic signed [SUM_W-1:0] hsum [LANES];
	logic [SUM_W-1:0]        hmag [LANES];
	logic signed [COORD_W-1:0] anchor [LANES];
	logic signed [D_W-1:0]   cmag [LANES];
	logic signed [D_W-1:0]   cval [LANES];
	logic signed [D_W-1:0]   dn [LANES];
	logic signed [GRAD_W-1:0] grad [LANES];

	logic                    div_start;
	logic [PROD_W-1:0]       div_dividend [LANES];
	logic [DIVR_W-1:0]       div_divisor;
	logic [LANES-1:0]        div_busy;
	logic [PROD_W-1:0]       div_quot [LANES];
	logic [LANES-1:0]        div_rnd;

	logic [COORD_W-1:0]      mul_a;
	logic [COORD_W-1:0]      mul_b;
	logic                    e_sat;
	logic [ENERGY_W-1:0]     energy;

	// Round the gradient quotient, clamp to the 48-bit range and apply the sign
	function automatic logic signed [GRAD_W-1:0] sat_grad(
		input logic [PROD_W-1:0] quot,
		input logic              rnd,
		input logic              neg
	);
		logic [PROD_W:0] q;
		logic [PROD_W:0] lim;
		q   = {1'b0, quot} + (PROD_W + 1)'(rnd);
		lim = neg ? (PROD_W + 1)'(1) << (GRAD_W - 1) :
			((PROD_W + 1)'(1) << (GRAD_W - 1)) - 1'b1;
		if (q > lim) begin
			q = lim;
		end
		if (neg) begin
			q = -q;
		end
		return signed'(q[GRAD_W-1:0]);
	endfunction

	assign hsum[0]   = q_head.sum_x;
	assign hsum[1]   = q_head.sum_y;
	assign hsum[2]   = q_head.sum_z;
	assign anchor[0] = cfg.anchor_x;
	assign anchor[1] = cfg.anchor_y;
	assign anchor[2] = cfg.anchor_z;

	assign q_pop       = (state_q == S_IDLE) && !q_empty;
	assign div_start   = q_pop || (state_q == S_GSTART);
	assign div_divisor = (state_q == S_IDLE) ? DIVR_W'(q_head.atom_count) :
		{n_q, {(COORD_FRAC_BITS - 1){1'b0}}};

	// Per-lane magnitudes, centroid rounding, displacement and gradient saturation
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			hmag[i]         = hsum[i][SUM_W-1] ? -hsum[i] : hsum[i];
			div_dividend[i] = (state_q == S_IDLE) ? PROD_W'(hmag[i]) : mag_q[i];
			cmag[i]         = D_W'(div_quot[i][C_W-1:0]) + D_W'(div_rnd[i]);
			cval[i]         = sneg_q[i] ? -cmag[i] : cmag[i];
			dn[i]           = cval[i] - D_W'(anchor[i]);
			mag_d[i]        = d_q[i][D_W-1] ? MAG_W'(-d_q[i]) : MAG_W'(d_q[i]);
			grad[i]         = sat_grad(div_quot[i], div_rnd[i], d_q[i][D_W-1]);
		end
	end

	// Select multiplier operands for the current step
	always_comb begin
		case (step_q)
			MS_SQ_X: begin
				mul_a = mag_d[0];
				mul_b = mag_d[0];
			end
			MS_SQ_Y: begin
				mul_a = mag_d[1];
				mul_b = mag_d[1];
			end
			MS_SQ_Z: begin
				mul_a = mag_d[2];
				mul_b = mag_d[2];
			end
			MS_E_LO: begin
				mul_a = s_q[COORD_W-1:0];
				mul_b = cfg.force_constant;
			end
			MS_E_MID: begin
				mul_a = s_q[2*COORD_W-1:COORD_W];
				mul_b = cfg.force_constant;
			end
			MS_E_HI: begin
				mul_a = COORD_W'(s_q[SQ_W-1:2*COORD_W]);
				mul_b = cfg.force_constant;
			end
			MS_G_X: begin
				mul_a = mag_d[0];
				mul_b = cfg.force_constant;
			end
			MS_G_Y: begin
				mul_a = mag_d[1];
				mul_b = cfg.force_constant;
			end
			MS_G_Z: begin
				mul_a = mag_d[2];
				mul_b = cfg.force_constant;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Shift the rounded energy down and saturate
	assign e_sat  = |p_q[EACC_W-1:E_SH+ENERGY_W];
	assign energy = e_sat ? {ENERGY_W{1'b1}} : p_q[E_SH+ENERGY_W-1:E_SH];

	// Sequence the group through division, products and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= MS_SQ_X;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (!q_empty) begin
						n_q   <= q_head.atom_count;
						ovf_q <= q_head.count_overflow;
						for (int i = 0; i < LANES; i++) begin
							sneg_q[i] <= hsum[i][SUM_W-1];
						end
						state_q <= S_CDIV;
					end
				end
				S_CDIV: begin
					if (!div_busy[0]) begin
						for (int i = 0; i < LANES; i++) begin
							d_q[i] <= dn[i];
						end
						step_q  <= MS_SQ_X;
						phase_q <= 1'b0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					phase_q <= !phase_q;
					if (!phase_q) begin
						prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
					end else begin
						case (step_q)
							MS_SQ_X:  s_q <= SQ_W'(prod_q);
							MS_SQ_Y,
							MS_SQ_Z:  s_q <= s_q + SQ_W'(prod_q);
							MS_E_LO:  p_q <= EACC_W'(prod_q) + E_HALF;
							MS_E_MID: p_q <= p_q + (EACC_W'(prod_q) << COORD_W);
							MS_E_HI:  p_q <= p_q + (EACC_W'(prod_q) << (2 * COORD_W));
							MS_G_X:   mag_q[0] <= prod_q;
							MS_G_Y:   mag_q[1] <= prod_q;
							MS_G_Z:   mag_q[2] <= prod_q;
							default:  s_q <= s_q;
						endcase
						if (step_q == MS_G_Z) begin
							state_q <= S_GSTART;
						end else begin
							step_q <= mul_step_t'(step_q + 4'd1);
						end
					end
				end
				S_GSTART: begin
					state_q <= S_GDIV;
				end
				S_GDIV: begin
					if (!div_busy[0]) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q                <= 1'b1;
						out_data_q.energy          <= energy;
						out_data_q.grad_x          <= grad[0];
						out_data_q.grad_y          <= grad[1];
						out_data_q.grad_z          <= grad[2];
						out_data_q.too_many_atoms  <= ovf_q;
						state_q                    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// One divider per axis, used for the centroid and then for the gradient
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		csr_div u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.start    (div_start),
			.dividend (div_dividend[g]),
			.divisor  (div_divisor),
			.busy     (div_busy[g]),
			.quotient (div_quot[g]),
			.round_up (div_rnd[g])
		);
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== rtl/centroid_spring_restraint.sv =====
// Centroid spring restraint top level: configuration registers, front end, group queue, back end.
//
// Atoms stream in one per cycle as signed Q16.16 coordinates; the atom flagged
// last_atom closes the group and yields one result (energy fk*|d|^2 and the
// per-atom gradient decrement 2*fk*d/n, both saturating), other atoms yield
// none. The front end takes an atom every cycle and keeps accumulating the next
// group while the back end works on a closed one; up to two closed groups wait
// in the queue, and the input stalls only when that queue is full. The back end
// handles one group at a time: a pass of the 64-step bit-serial dividers for the
// centroid, a shared 32x32 multiplier for the squares and products, and a second
// divider pass for the gradient, three axes in parallel. It takes a new group
// only after emitting the last result, so short groups can fill the queue and
// stall the input. Atoms past 1024 in a group are dropped and flagged in
// too_many_atoms. Registers sit on an APB port at byte addresses
// 0 (force_constant), 4, 8, 12 (anchor x, y, z); the user writes them only
// while no group is in flight, and the block itself does not enforce this.
module centroid_spring_restraint (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [csr_pkg::ADDR_W-1:0]  paddr,
	input  logic [csr_pkg::DATA_W-1:0]  pwdata,
	output logic [csr_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  csr_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output csr_pkg::out_item_t          out_data
);
	import csr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     q_push;
	logic     q_pop;
	logic     q_full;
	logic     q_empty;
	group_t   q_group;
	group_t   q_head;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	// Write configuration on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_FORCE_CONSTANT: cfg_q.force_constant <= pwdata;
				REG_ANCHOR_X:       cfg_q.anchor_x       <= signed'(pwdata);
				REG_ANCHOR_Y:       cfg_q.anchor_y       <= signed'(pwdata);
				REG_ANCHOR_Z:       cfg_q.anchor_z       <= signed'(pwdata);
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	// Read back configuration
	always_comb begin
		case (reg_idx)
			REG_FORCE_CONSTANT: prdata = cfg_q.force_constant;
			REG_ANCHOR_X:       prdata = cfg_q.anchor_x;
			REG_ANCHOR_Y:       prdata = cfg_q.anchor_y;
			REG_ANCHOR_Z:       prdata = cfg_q.anchor_z;
			default:            prdata = '0;
		endcase
	end

	csr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_group  (q_group)
	);

	csr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_group),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	csr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// A closed group never lands on a full queue
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("group pushed into a full queue");

	// The transfer of a last atom leaves a group waiting for the back end
	a_last_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && in_data.last_atom) |=> !q_empty)
		else $error("closed group missing from the queue");

	// A zero force constant gives zero energy and zero gradient
	a_zero_force: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (cfg_q.force_constant == '0)) |->
		(out_data.energy == '0 && out_data.grad_x == '0 &&
		 out_data.grad_y == '0 && out_data.grad_z == '0))
		else $error("nonzero result with zero force constant");

endmodule
